// ===== src/shcfp_pkg.sv =====
package shcfp_pkg;

  localparam int ABS_OUT_MAX  = 32767;
  localparam int ABS_IN_MAX   = 4095;
  localparam int KEPT_PAYLOAD = 8;
  localparam int HEAD_IDX_W   = $clog2(KEPT_PAYLOAD);

  localparam logic [7:0] HDR_A   = 8'h57;
  localparam logic [7:0] HDR_B   = 8'hAB;
  localparam logic [7:0] MAX_LEN = 8'd249;

  // frame byte positions
  localparam logic [7:0] POS_HDR_A = 8'd0;
  localparam logic [7:0] POS_HDR_B = 8'd1;
  localparam logic [7:0] POS_CMD   = 8'd3;
  localparam logic [7:0] POS_LEN   = 8'd4;
  localparam logic [7:0] POS_DATA  = 8'd5;

  localparam logic [1:0] ST_MORE   = 2'd0;
  localparam logic [1:0] ST_DROP   = 2'd1;
  localparam logic [1:0] ST_ACCEPT = 2'd2;

  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_VERSION  = 3'd1;
  localparam logic [2:0] ACT_KEYBOARD = 3'd2;
  localparam logic [2:0] ACT_REL      = 3'd3;
  localparam logic [2:0] ACT_ABS      = 3'd4;
  localparam logic [2:0] ACT_RESTART  = 3'd5;

  localparam logic [7:0] CMD_VERSION  = 8'h01;
  localparam logic [7:0] CMD_KEYBOARD = 8'h02;
  localparam logic [7:0] CMD_ABS      = 8'h04;
  localparam logic [7:0] CMD_REL      = 8'h05;
  localparam logic [7:0] CMD_RESTART  = 8'h0F;

  localparam logic [7:0] MODE_REL = 8'h01;
  localparam logic [7:0] MODE_ABS = 8'h02;

  localparam logic [7:0] KBD_MIN_LEN = 8'd8;
  localparam logic [7:0] REL_MIN_LEN = 8'd5;
  localparam logic [7:0] ABS_MIN_LEN = 8'd7;

  typedef struct packed {
    logic [1:0]        frame_status;
    logic [2:0]        action;
    logic [7:0]        buttons;
    logic [47:0]       key_codes;
    logic [14:0]       abs_x;
    logic [14:0]       abs_y;
    logic signed [7:0] rel_dx;
    logic signed [7:0] rel_dy;
    logic signed [7:0] wheel;
  } shcfp_result_t;

endpackage

// ===== src/serial_hid_command_frame_parser.sv =====
// Path: an accepted input word passes the input register and then the result register.
// Throughput: one word per cycle while the output is not stalled; the frame state updates
// as a word moves from the input register into the result register.
// Reset: synchronous, active low; clears both valid flags and the frame state
// (position, command, length, checksum). The data head needs no clearing.
module serial_hid_command_frame_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_frame_status,
  output logic [2:0]         out_action,
  output logic [7:0]         out_buttons,
  output logic [47:0]        out_key_codes,
  output logic [14:0]        out_abs_x,
  output logic [14:0]        out_abs_y,
  output logic signed [7:0]  out_rel_dx,
  output logic signed [7:0]  out_rel_dy,
  output logic signed [7:0]  out_wheel
);
  import shcfp_pkg::*;

  logic          byte_valid;
  logic [7:0]    byte_q;
  logic          out_free;
  logic          advance;
  shcfp_result_t result;
  shcfp_result_t result_q;

  assign advance = byte_valid && out_free;

  shcfp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take       (advance),
    .byte_valid (byte_valid),
    .byte_q     (byte_q)
  );

  shcfp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (advance),
    .rx_byte (byte_q),
    .result  (result)
  );

  shcfp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .result    (result),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result_q  (result_q)
  );

  assign out_frame_status = result_q.frame_status;
  assign out_action       = result_q.action;
  assign out_buttons      = result_q.buttons;
  assign out_key_codes    = result_q.key_codes;
  assign out_abs_x        = result_q.abs_x;
  assign out_abs_y        = result_q.abs_y;
  assign out_rel_dx       = result_q.rel_dx;
  assign out_rel_dy       = result_q.rel_dy;
  assign out_wheel        = result_q.wheel;

endmodule

// ===== src/shcfp_in_stage.sv =====
module shcfp_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_q
);
  import shcfp_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;

  assign in_ready   = !valid_r || take;
  assign byte_valid = valid_r;
  assign byte_q     = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

// ===== src/shcfp_core.sv =====
module shcfp_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    take,
  input  logic [7:0]              rx_byte,
  output shcfp_pkg::shcfp_result_t result
);
  import shcfp_pkg::*;

  localparam int ABS_DIV = ABS_IN_MAX + 1;

  logic [7:0] pos_r, pos_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] head_r [KEPT_PAYLOAD];

  logic                  is_cksum;
  logic                  head_wr;
  logic [7:0]            data_off;
  logic [HEAD_IDX_W-1:0] head_idx;

  function automatic logic [14:0] scale_abs(input logic [7:0] lo, input logic [7:0] hi);
    logic [31:0] prod;
    logic [31:0] q;
    begin
      prod = 32'({hi, lo}) * 32'(ABS_OUT_MAX + 1);
      q    = prod / ABS_DIV;
      if (q > 32'(ABS_OUT_MAX)) begin
        scale_abs = 15'(ABS_OUT_MAX);
      end else begin
        scale_abs = q[14:0];
      end
    end
  endfunction

  assign data_off = pos_r - POS_DATA;
  assign head_idx = data_off[HEAD_IDX_W-1:0];
  assign is_cksum = (pos_r >= POS_DATA) &&
                    ({1'b0, pos_r} == {1'b0, POS_DATA} + {1'b0, len_r});

  always_comb begin
    result  = '0;
    pos_nxt = pos_r;
    cmd_nxt = cmd_r;
    len_nxt = len_r;
    sum_nxt = sum_r;
    head_wr = 1'b0;
    priority if (pos_r == POS_HDR_A && rx_byte != HDR_A) begin
      result.frame_status = ST_DROP;
      pos_nxt = '0;
      sum_nxt = '0;
    end else if (pos_r == POS_HDR_B && rx_byte != HDR_B) begin
      result.frame_status = ST_DROP;
      pos_nxt = '0;
      sum_nxt = '0;
    end else if (pos_r == POS_LEN && rx_byte > MAX_LEN) begin
      result.frame_status = ST_DROP;
      pos_nxt = '0;
      sum_nxt = '0;
    end else if (is_cksum) begin
      pos_nxt = '0;
      sum_nxt = '0;
      if (rx_byte != sum_r) begin
        result.frame_status = ST_DROP;
      end else begin
        result.frame_status = ST_ACCEPT;
        unique case (cmd_r)
          CMD_VERSION: begin
            result.action = ACT_VERSION;
          end
          CMD_KEYBOARD: begin
            if (len_r >= KBD_MIN_LEN) begin
              result.action    = ACT_KEYBOARD;
              result.buttons   = head_r[0];
              result.key_codes = {head_r[7], head_r[6], head_r[5],
                                  head_r[4], head_r[3], head_r[2]};
            end
          end
          CMD_REL: begin
            if (len_r >= REL_MIN_LEN && head_r[0] == MODE_REL) begin
              result.action  = ACT_REL;
              result.buttons = head_r[1];
              result.rel_dx  = head_r[2];
              result.rel_dy  = head_r[3];
              result.wheel   = head_r[4];
            end
          end
          CMD_ABS: begin
            if (len_r >= ABS_MIN_LEN && head_r[0] == MODE_ABS) begin
              result.action  = ACT_ABS;
              result.buttons = head_r[1];
              result.abs_x   = scale_abs(head_r[2], head_r[3]);
              result.abs_y   = scale_abs(head_r[4], head_r[5]);
              result.wheel   = head_r[6];
            end
          end
          CMD_RESTART: begin
            result.action = ACT_RESTART;
          end
          default: begin
            result.frame_status = ST_DROP;
          end
        endcase
      end
    end else begin
      if (pos_r == POS_CMD) begin
        cmd_nxt = rx_byte;
      end else if (pos_r == POS_LEN) begin
        len_nxt = rx_byte;
      end else if (pos_r >= POS_DATA && data_off < 8'(KEPT_PAYLOAD)) begin
        head_wr = 1'b1;
      end
      sum_nxt = sum_r + rx_byte;
      pos_nxt = pos_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      cmd_r <= '0;
      len_r <= '0;
      sum_r <= '0;
    end else if (take) begin
      pos_r <= pos_nxt;
      cmd_r <= cmd_nxt;
      len_r <= len_nxt;
      sum_r <= sum_nxt;
    end
  end

  // first data words of the frame; only read after being written this frame
  always_ff @(posedge clk) begin
    if (take && head_wr) begin
      head_r[head_idx] <= rx_byte;
    end
  end

endmodule

// ===== src/shcfp_out_stage.sv =====
module shcfp_out_stage (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    load,
  input  shcfp_pkg::shcfp_result_t result,
  output logic                    free,
  output logic                    out_valid,
  input  logic                    out_ready,
  output shcfp_pkg::shcfp_result_t result_q
);
  import shcfp_pkg::*;

  logic          valid_r, valid_nxt;
  shcfp_result_t result_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign result_q  = result_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

endmodule

// ===== src/shcfp_checker.sv =====
module shcfp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_frame_status,
  input logic [2:0]         out_action,
  input logic [7:0]         out_buttons,
  input logic [47:0]        out_key_codes,
  input logic [14:0]        out_abs_x,
  input logic [14:0]        out_abs_y,
  input logic signed [7:0]  out_rel_dx,
  input logic signed [7:0]  out_rel_dy,
  input logic signed [7:0]  out_wheel
);
  import shcfp_pkg::*;

  // nothing comes out of reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_status) &&
    $stable(out_action) && $stable(out_buttons) && $stable(out_key_codes))
    else $error("stalled result word changed");

  // only accepted frames carry an action or data
  a_quiet_unless_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_status != ST_ACCEPT |->
    out_action == ACT_NONE && out_buttons == 8'd0 && out_key_codes == 48'd0 &&
    out_abs_x == 15'd0 && out_abs_y == 15'd0 && out_wheel == 8'sd0)
    else $error("data on a word that is not an accepted frame");

  a_keyboard_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_KEYBOARD |->
    out_frame_status == ST_ACCEPT && out_abs_x == 15'd0 && out_abs_y == 15'd0 &&
    out_rel_dx == 8'sd0 && out_rel_dy == 8'sd0 && out_wheel == 8'sd0)
    else $error("keyboard word carries mouse fields");

  a_rel_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_REL |->
    out_key_codes == 48'd0 && out_abs_x == 15'd0 && out_abs_y == 15'd0)
    else $error("relative mouse word carries other fields");

endmodule

bind serial_hid_command_frame_parser shcfp_checker u_shcfp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_frame_status (out_frame_status),
  .out_action       (out_action),
  .out_buttons      (out_buttons),
  .out_key_codes    (out_key_codes),
  .out_abs_x        (out_abs_x),
  .out_abs_y        (out_abs_y),
  .out_rel_dx       (out_rel_dx),
  .out_rel_dy       (out_rel_dy),
  .out_wheel        (out_wheel)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import shcfp_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int CYCLE_LIMIT = 200000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_rx_byte;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_frame_status;
  logic [2:0]         out_action;
  logic [7:0]         out_buttons;
  logic [47:0]        out_key_codes;
  logic [14:0]        out_abs_x;
  logic [14:0]        out_abs_y;
  logic signed [7:0]  out_rel_dx;
  logic signed [7:0]  out_rel_dy;
  logic signed [7:0]  out_wheel;

  serial_hid_command_frame_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_status (out_frame_status),
    .out_action       (out_action),
    .out_buttons      (out_buttons),
    .out_key_codes    (out_key_codes),
    .out_abs_x        (out_abs_x),
    .out_abs_y        (out_abs_y),
    .out_rel_dx       (out_rel_dx),
    .out_rel_dy       (out_rel_dy),
    .out_wheel        (out_wheel)
  );

  // parser state as the testbench sees it
  logic [8:0] parse_pos;
  logic [7:0] cmd_byte;
  logic [7:0] len_byte;
  logic [7:0] sum_byte;
  logic [7:0] data_head [KEPT_PAYLOAD];

  shcfp_result_t pending_results[$];
  int mismatches;
  int words_sent;
  int cycle_count;
  int src_idle_pct;
  int sink_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic logic [14:0] scale_coord(input logic [7:0] lo, input logic [7:0] hi);
    longint v;
    v = longint'({hi, lo}) * (ABS_OUT_MAX + 1) / (ABS_IN_MAX + 1);
    if (v > ABS_OUT_MAX) v = ABS_OUT_MAX;
    return v[14:0];
  endfunction

  // advances the parser state by one word and returns the result word it yields
  function automatic shcfp_result_t parse_word(input logic [7:0] b);
    shcfp_result_t r;
    logic [8:0] pos;
    r = '0;
    pos = parse_pos;
    r.frame_status = ST_MORE;
    if ((pos == POS_HDR_A && b != HDR_A) || (pos == POS_HDR_B && b != HDR_B) ||
        (pos == POS_LEN && b > MAX_LEN)) begin
      r.frame_status = ST_DROP;
      parse_pos = '0;
      sum_byte = '0;
    end else if (pos >= POS_DATA && pos == 9'(POS_DATA) + 9'(len_byte)) begin
      if (b != sum_byte) begin
        r.frame_status = ST_DROP;
      end else begin
        r.frame_status = ST_ACCEPT;
        case (cmd_byte)
          CMD_VERSION: r.action = ACT_VERSION;
          CMD_KEYBOARD: begin
            if (len_byte >= KBD_MIN_LEN) begin
              r.action = ACT_KEYBOARD;
              r.buttons = data_head[0];
              r.key_codes = {data_head[7], data_head[6], data_head[5],
                             data_head[4], data_head[3], data_head[2]};
            end
          end
          CMD_REL: begin
            if (len_byte >= REL_MIN_LEN && data_head[0] == MODE_REL) begin
              r.action = ACT_REL;
              r.buttons = data_head[1];
              r.rel_dx = data_head[2];
              r.rel_dy = data_head[3];
              r.wheel = data_head[4];
            end
          end
          CMD_ABS: begin
            if (len_byte >= ABS_MIN_LEN && data_head[0] == MODE_ABS) begin
              r.action = ACT_ABS;
              r.buttons = data_head[1];
              r.abs_x = scale_coord(data_head[2], data_head[3]);
              r.abs_y = scale_coord(data_head[4], data_head[5]);
              r.wheel = data_head[6];
            end
          end
          CMD_RESTART: r.action = ACT_RESTART;
          default: r.frame_status = ST_DROP;
        endcase
      end
      parse_pos = '0;
      sum_byte = '0;
    end else begin
      if (pos == POS_CMD) cmd_byte = b;
      else if (pos == POS_LEN) len_byte = b;
      else if (pos >= POS_DATA && pos - POS_DATA < KEPT_PAYLOAD)
        data_head[3'(pos - POS_DATA)] = b;
      sum_byte = sum_byte + b;
      parse_pos = pos + 9'd1;
    end
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [47:0] want,
                               input logic [47:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    shcfp_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual status %0h action %0h",
                 $time, out_frame_status, out_action);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("frame_status", 48'(want.frame_status), 48'(out_frame_status));
        compare_field("action", 48'(want.action), 48'(out_action));
        compare_field("buttons", 48'(want.buttons), 48'(out_buttons));
        compare_field("key_codes", want.key_codes, out_key_codes);
        compare_field("abs_x", 48'(want.abs_x), 48'(out_abs_x));
        compare_field("abs_y", 48'(want.abs_y), 48'(out_abs_y));
        compare_field("rel_dx", 48'($unsigned(want.rel_dx)), 48'($unsigned(out_rel_dx)));
        compare_field("rel_dy", 48'($unsigned(want.rel_dy)), 48'($unsigned(out_rel_dy)));
        compare_field("wheel", 48'($unsigned(want.wheel)), 48'($unsigned(out_wheel)));
      end
    end
  end

  // valid stays high across back-to-back words; it only drops for an idle gap
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(parse_word(b));
    words_sent++;
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_frame(input logic [7:0] cmd, input byte_q_t data, input bit bad_sum);
    logic [7:0] addr;
    logic [7:0] sum;
    addr = 8'($urandom);
    sum = HDR_A + HDR_B + addr + cmd + 8'(data.size());
    foreach (data[i]) sum = sum + data[i];
    send_byte(HDR_A);
    send_byte(HDR_B);
    send_byte(addr);
    send_byte(cmd);
    send_byte(8'(data.size()));
    foreach (data[i]) send_byte(data[i]);
    send_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
  endtask

  // bring the parser back to a frame start
  task automatic realign();
    while (parse_pos != 0) begin
      if (parse_pos == POS_HDR_B) send_byte(8'h00);
      else if (parse_pos == POS_LEN) send_byte(8'hFF);
      else send_byte(8'($urandom));
    end
  endtask

  task automatic send_header_to_len(input logic [7:0] len);
    send_byte(HDR_A);
    send_byte(HDR_B);
    send_byte(8'($urandom));
    send_byte(CMD_KEYBOARD);
    send_byte(len);
  endtask

  task automatic test_bad_header();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR_A);
    send_byte(8'h00);
    send_byte(HDR_A);
    send_byte(HDR_A);
    realign();
  endtask

  task automatic test_length_limit();
    byte_q_t data;
    send_header_to_len(8'd250);
    send_header_to_len(8'd255);
    data = {};
    repeat (MAX_LEN) data.push_back(8'($urandom));
    send_frame(CMD_KEYBOARD, data, 1'b0);
  endtask

  task automatic test_actions();
    byte_q_t data;
    data = {};
    send_frame(CMD_VERSION, data, 1'b0);
    data = '{8'hFF, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'hFF};
    send_frame(CMD_KEYBOARD, data, 1'b0);
    data = '{MODE_REL, 8'hFF, 8'h80, 8'h7F, 8'h81};
    send_frame(CMD_REL, data, 1'b0);
    data = '{MODE_ABS, 8'h07, 8'hFF, 8'h0F, 8'h00, 8'h00, 8'h80};
    send_frame(CMD_ABS, data, 1'b0);
    // coordinate far above the input range clamps
    data = '{MODE_ABS, 8'h00, 8'hFF, 8'hFF, 8'h01, 8'h10, 8'h7F, 8'hAA};
    send_frame(CMD_ABS, data, 1'b0);
    data = {};
    send_frame(CMD_RESTART, data, 1'b0);
    send_frame(CMD_VERSION, data, 1'b0);
  endtask

  task automatic test_no_action();
    byte_q_t data;
    data = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07};
    send_frame(CMD_KEYBOARD, data, 1'b0);
    data = '{MODE_REL, 8'h01, 8'h02, 8'h03};
    send_frame(CMD_REL, data, 1'b0);
    data = '{MODE_ABS, 8'h01, 8'h02, 8'h03, 8'h04};
    send_frame(CMD_REL, data, 1'b0);
    data = '{MODE_ABS, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
    send_frame(CMD_ABS, data, 1'b0);
    data = '{MODE_REL, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06};
    send_frame(CMD_ABS, data, 1'b0);
    data = {};
    send_frame(CMD_REL, data, 1'b0);
  endtask

  task automatic test_drops();
    byte_q_t data;
    data = '{8'h11, 8'h22};
    send_frame(CMD_VERSION, data, 1'b1);
    send_frame(8'h03, data, 1'b0);
    data = {};
    send_frame(8'h00, data, 1'b0);
    send_frame(8'hFF, data, 1'b0);
  endtask

  task automatic send_random_frame();
    logic [7:0] cmd;
    logic [15:0] coord;
    int len;
    byte_q_t data;
    realign();
    case ($urandom_range(5))
      0: cmd = CMD_VERSION;
      1: cmd = CMD_KEYBOARD;
      2: cmd = CMD_REL;
      3: cmd = CMD_ABS;
      4: cmd = CMD_RESTART;
      default: cmd = 8'($urandom);
    endcase
    case (cmd)
      CMD_KEYBOARD: len = KBD_MIN_LEN + $urandom_range(2);
      CMD_REL: len = REL_MIN_LEN + $urandom_range(2);
      CMD_ABS: len = ABS_MIN_LEN + $urandom_range(2);
      default: len = $urandom_range(3);
    endcase
    if ($urandom_range(7) == 0) len = $urandom_range(12);
    if ($urandom_range(29) == 0) len = $urandom_range(13, 60);
    data = {};
    repeat (len) data.push_back(8'($urandom));
    if (len > 0 && $urandom_range(7) != 0) begin
      if (cmd == CMD_REL) data[0] = MODE_REL;
      if (cmd == CMD_ABS) data[0] = MODE_ABS;
    end
    if (cmd == CMD_ABS && len >= 6) begin
      for (int i = 2; i < 6; i += 2) begin
        coord = $urandom_range(1) ? 16'($urandom_range(ABS_IN_MAX + 64)) : 16'($urandom);
        data[i] = coord[7:0];
        data[i + 1] = coord[15:8];
      end
    end
    send_frame(cmd, data, $urandom_range(9) == 0);
  endtask

  task automatic test_random(input int n_words);
    int stop_at;
    int pick;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        send_random_frame();
      end else if (pick < 87) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else if (pick < 92) begin
        realign();
        send_byte(HDR_A);
        send_byte(8'($urandom_range(1) ? 8'h00 : $urandom));
      end else if (pick < 96) begin
        realign();
        send_header_to_len(8'($urandom_range(MAX_LEN + 1, 255)));
      end else begin
        // truncated frame followed by a fresh one
        realign();
        send_byte(HDR_A);
        send_byte(HDR_B);
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end
    end
    realign();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = '0;
    out_ready = 1'b0;
    mismatches = 0;
    words_sent = 0;
    cycle_count = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    parse_pos = '0;
    cmd_byte = '0;
    len_byte = '0;
    sum_byte = '0;
    foreach (data_head[i]) data_head[i] = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_bad_header();
    test_length_limit();
    test_actions();
    test_no_action();
    test_drops();
    wait_results();

    test_random(25);
    wait_results();
    src_idle_pct = 63;
    test_random(25);
    wait_results();
    src_idle_pct = 0;
    sink_stall_pct = 63;
    test_random(25);
    wait_results();
    src_idle_pct = 18;
    sink_stall_pct = 18;
    test_random(25);
    wait_results();

    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
